// ===== hdl/jsu_pkg.sv =====
// jsu_pkg: shared types and character constants for the json string unescaper
// no dependencies; used by json_string_unescape, jsu_front, jsu_queue and jsu_back

package jsu_pkg;

  // longest burst of output bytes caused by one input byte
  localparam int unsigned RunMax = 5;

  // character codes
  localparam logic [7:0] CH_BSL = 8'h5C;  // backslash
  localparam logic [7:0] CH_U   = 8'h75;  // 'u'
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_T   = 8'h74;

  // utf-8 lead and continuation markers
  localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF_CONT  = 8'h80;
  localparam logic [7:0]  UTF_MASK6 = 8'h3F;
  localparam logic [15:0] UTF_ONE_MAX = 16'h0080;
  localparam logic [15:0] UTF_TWO_MAX = 16'h0800;

  // one run of output bytes produced by a single input word
  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    logic [2:0]             count;  // 1..5 when queued
  } run_t;

  // status of the run queue seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/jsu_if.sv =====
// jsu_if: valid/ready channel interfaces for raw input words and unescaped output words
// no dependencies

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== hdl/json_string_unescape.sv =====
// json_string_unescape: top level of the streaming json string unescaper
// depends on jsu_pkg, jsu_if, jsu_front, jsu_queue and jsu_back
//
// Usage:
//   in_ch carries one raw byte of a json string body per word, with is_final
//   set on the last byte of the string. out_ch carries the unescaped bytes;
//   run_last marks the last output byte caused by one input byte. Escapes
//   \" \\ \/ \b \f \n \r \t are translated, \uXXXX becomes 1 to 3 bytes of
//   utf-8, and a byte that produces no output (backslash, held hex digit)
//   only updates the decode state.
//   An accepted byte is classified in the same cycle and its run of 1 to 5
//   bytes goes into a QDEPTH-entry run queue; the run is registered in the
//   queue before its first byte is offered on out_ch. The back end sends one
//   byte per cycle while out_ch.ready is high, a run of n bytes as n words;
//   single-byte runs flow at one input byte per cycle while ready stays high.
//   in_ch.ready drops only when the run queue is full, so input keeps flowing
//   while the receiver stalls until QDEPTH runs are waiting.
//   Synchronous reset returns to plain text mode and empties the queue.

module json_string_unescape #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);

  logic              push;
  logic              pop;
  jsu_pkg::run_t     push_run;
  jsu_pkg::run_t     head;
  jsu_pkg::q_stat_t  q_stat;

  // input classification and escape decoding
  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_run (push_run)
  );

  // run queue
  jsu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // byte serializer
  jsu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== hdl/jsu_front.sv =====
// jsu_front: accepts raw words, tracks escape state and builds output runs
// depends on jsu_pkg and jsu_if

module jsu_front (
  input  logic              clk,
  input  logic              rst,
  jsu_in_if.sink            in_ch,
  input  jsu_pkg::q_stat_t  q_stat,
  output logic              push,
  output jsu_pkg::run_t     push_run
);

  typedef enum logic [5:0] {
    ST_TEXT = 6'b000001,
    ST_ESC  = 6'b000010,
    ST_HEX0 = 6'b000100,
    ST_HEX1 = 6'b001000,
    ST_HEX2 = 6'b010000,
    ST_HEX3 = 6'b100000
  } state_t;

  state_t           mode;
  state_t           mode_next;
  logic [11:0]      cp;
  logic [11:0]      cp_next;
  logic [2:0][7:0]  held;
  logic             held_we;
  logic [1:0]       held_cnt;
  logic             accept;
  logic [7:0]       b;
  logic             fin;
  logic             hex_ok;
  logic [3:0]       hex_val;
  logic [15:0]      cp_full;
  logic             do_text;
  logic [2:0]       text_pos;
  jsu_pkg::run_t    run;

  assign b      = in_ch.in_byte;
  assign fin    = in_ch.is_final;
  assign in_ch.ready = !q_stat.full;
  assign accept = in_ch.valid && !q_stat.full;

  // hex digit decode, either case
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_val = 4'(b - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // number of hex digits already held
  always_comb begin
    unique case (mode)
      ST_HEX1: held_cnt = 2'd1;
      ST_HEX2: held_cnt = 2'd2;
      ST_HEX3: held_cnt = 2'd3;
      default: held_cnt = 2'd0;
    endcase
  end

  assign cp_full = {cp, hex_val};

  // classify the word and build its run
  always_comb begin
    mode_next = mode;
    cp_next   = cp;
    held_we   = 1'b0;
    run       = '0;
    do_text   = 1'b0;
    text_pos  = 3'd0;
    unique case (mode)
      ST_ESC: begin
        mode_next = ST_TEXT;
        run.count = 3'd1;
        unique case (b)
          jsu_pkg::CH_B: run.bytes[0] = 8'h08;
          jsu_pkg::CH_F: run.bytes[0] = 8'h0C;
          jsu_pkg::CH_N: run.bytes[0] = 8'h0A;
          jsu_pkg::CH_R: run.bytes[0] = 8'h0D;
          jsu_pkg::CH_T: run.bytes[0] = 8'h09;
          jsu_pkg::CH_U: begin
            run.bytes[0] = jsu_pkg::CH_U;
            if (!fin) begin
              mode_next = ST_HEX0;
              cp_next   = '0;
              run.count = 3'd0;
            end
          end
          default: run.bytes[0] = b;
        endcase
      end
      ST_HEX0, ST_HEX1, ST_HEX2, ST_HEX3: begin
        if (hex_ok && held_cnt == 2'd3) begin
          // fourth digit: emit utf-8 of the code point
          mode_next = ST_TEXT;
          cp_next   = '0;
          if (cp_full < jsu_pkg::UTF_ONE_MAX) begin
            run.bytes[0] = cp_full[7:0];
            run.count    = 3'd1;
          end else if (cp_full < jsu_pkg::UTF_TWO_MAX) begin
            run.bytes[0] = jsu_pkg::UTF_LEAD2 | {3'b000, cp_full[10:6]};
            run.bytes[1] = jsu_pkg::UTF_CONT | ({2'b00, cp_full[5:0]} & jsu_pkg::UTF_MASK6);
            run.count    = 3'd2;
          end else begin
            run.bytes[0] = jsu_pkg::UTF_LEAD3 | {4'h0, cp_full[15:12]};
            run.bytes[1] = jsu_pkg::UTF_CONT | ({2'b00, cp_full[11:6]} & jsu_pkg::UTF_MASK6);
            run.bytes[2] = jsu_pkg::UTF_CONT | ({2'b00, cp_full[5:0]} & jsu_pkg::UTF_MASK6);
            run.count    = 3'd3;
          end
        end else if (hex_ok && !fin) begin
          // hold the digit and keep accumulating
          held_we   = 1'b1;
          cp_next   = {cp[7:0], hex_val};
          mode_next = state_t'(mode << 1);
        end else begin
          // broken escape: replay 'u' and held digits, then treat as text
          mode_next    = ST_TEXT;
          cp_next      = '0;
          run.bytes[0] = jsu_pkg::CH_U;
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < held_cnt) begin
              run.bytes[i+1] = held[i];
            end
          end
          text_pos = 3'(held_cnt) + 3'd1;
          do_text  = 1'b1;
        end
      end
      default: begin
        mode_next = ST_TEXT;
        do_text   = 1'b1;
      end
    endcase

    // plain text handling at the current run position
    if (do_text) begin
      run.count = text_pos;
      if (b == jsu_pkg::CH_BSL) begin
        if (!fin) begin
          mode_next = ST_ESC;
        end
      end else begin
        run.bytes[text_pos] = b;
        run.count           = text_pos + 3'd1;
      end
    end

    // end of string returns to text mode
    if (fin) begin
      mode_next = ST_TEXT;
      cp_next   = '0;
    end
  end

  assign push     = accept && (run.count != 3'd0);
  assign push_run = run;

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ST_TEXT;
      cp   <= '0;
    end else if (accept) begin
      mode <= mode_next;
      cp   <= cp_next;
    end
  end

  // held digits, no reset
  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held[held_cnt] <= b;
    end
  end

endmodule

// ===== hdl/jsu_queue.sv =====
// jsu_queue: small register queue of output runs between front and back
// depends on jsu_pkg

module jsu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jsu_pkg::run_t     push_run,
  input  logic              pop,
  output jsu_pkg::run_t     head,
  output jsu_pkg::q_stat_t  q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  jsu_pkg::run_t    mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] fill;

  assign q_stat.full  = (fill == CNT_W'(DEPTH));
  assign q_stat.empty = (fill == '0);
  assign head         = mem[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // run storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_run;
    end
  end

endmodule

// ===== hdl/jsu_back.sv =====
// jsu_back: walks the head run of the queue and sends one byte per word
// depends on jsu_pkg and jsu_if

module jsu_back (
  input  logic              clk,
  input  logic              rst,
  input  jsu_pkg::run_t     head,
  input  jsu_pkg::q_stat_t  q_stat,
  output logic              pop,
  jsu_out_if.source         out_ch
);

  logic [2:0] idx;
  logic       last;
  logic       send;

  assign last = (idx == head.count - 3'd1);
  assign send = out_ch.valid && out_ch.ready;
  assign pop  = send && last;

  assign out_ch.valid    = !q_stat.empty;
  assign out_ch.out_byte = head.bytes[idx];
  assign out_ch.run_last = last;

  // position inside the current run
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (send) begin
      idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

endmodule
